[rtl/simp_pkg.sv]
// types, opcodes and control encodings shared by the simp risc executor
package simp_pkg;

	typedef enum logic [1:0] {
		CMD_MEM_WR = 2'd0,
		CMD_EXEC   = 2'd1,
		CMD_MEM_RD = 2'd2,
		CMD_REG_RD = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [11:0] addr;
		logic [31:0] data;
	} req_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic        halted;
		logic [31:0] read_data;
		logic [7:0]  executed_opcode;
	} rsp_t;

	localparam logic [7:0] OP_ADD  = 8'd0;
	localparam logic [7:0] OP_SUB  = 8'd1;
	localparam logic [7:0] OP_AND  = 8'd2;
	localparam logic [7:0] OP_OR   = 8'd3;
	localparam logic [7:0] OP_XOR  = 8'd4;
	localparam logic [7:0] OP_MUL  = 8'd5;
	localparam logic [7:0] OP_SLL  = 8'd6;
	localparam logic [7:0] OP_SRA  = 8'd7;
	localparam logic [7:0] OP_SRL  = 8'd8;
	localparam logic [7:0] OP_BEQ  = 8'd9;
	localparam logic [7:0] OP_BNE  = 8'd10;
	localparam logic [7:0] OP_BLT  = 8'd11;
	localparam logic [7:0] OP_BGT  = 8'd12;
	localparam logic [7:0] OP_BLE  = 8'd13;
	localparam logic [7:0] OP_BGE  = 8'd14;
	localparam logic [7:0] OP_JAL  = 8'd15;
	localparam logic [7:0] OP_LW   = 8'd16;
	localparam logic [7:0] OP_SW   = 8'd17;
	localparam logic [7:0] OP_HALT = 8'd21;

	localparam logic [3:0] REG_ZERO = 4'd0;
	localparam logic [3:0] REG_IMM  = 4'd1;
	localparam logic [3:0] REG_LINK = 4'd15;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ISSUE,
		S_DECODE,
		S_EXEC,
		S_COMMIT,
		S_LOAD,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_CLEAR,
		MEM_HOST_WR,
		MEM_HOST_RD,
		MEM_FETCH,
		MEM_LOAD,
		MEM_STORE
	} mem_op_t;

	typedef enum logic [1:0] {
		RF_RD_NONE,
		RF_RD_HOST,
		RF_RD_SRC,
		RF_RD_DST
	} rf_rd_t;

	typedef struct packed {
		mem_op_t mem_op;
		rf_rd_t  rf_rd;
		logic    load_req;
		logic    decode;
		logic    exec;
		logic    commit;
		logic    load_wb;
		logic    rsp_load;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic halted;
		logic clr_last;
		logic load_ok;
		logic store_ok;
	} stat_t;

endpackage

[rtl/simp_risc_instruction_executor.sv]
// top level of the simp risc instruction executor
// After reset the block clears main memory, one word a cycle, and accepts no item
// meanwhile. Each item then occupies the block alone: a memory write, memory read,
// register read or an execute while halted goes through issue and result; an executed
// instruction goes through fetch, decode with register reads, execute, commit, a load
// write-back for a load that hits memory, and result. The steps are set by the
// single-port synchronous main memory, which serves fetch and load in turn, and by the
// two read ports of the register file. The result sits in an output register, so the
// block returns to idle while a finished result waits to be taken.
module simp_risc_instruction_executor #(
	parameter int MEM_WORDS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  simp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output simp_pkg::rsp_t rsp
);

	simp_pkg::ctl_t  ctl;
	simp_pkg::stat_t stat;

	simp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	simp_dp #(
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

[rtl/simp_ctrl.sv]
// controller state machine sequencing host commands and instruction steps
module simp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  simp_pkg::stat_t   stat,
	output simp_pkg::ctl_t    ctl
);

	simp_pkg::state_t state_q, state_d;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= simp_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			simp_pkg::S_CLEAR: begin
				if (stat.clr_last) state_d = simp_pkg::S_IDLE;
			end
			simp_pkg::S_IDLE: begin
				if (req_valid) state_d = simp_pkg::S_ISSUE;
			end
			simp_pkg::S_ISSUE: begin
				if (stat.cmd == simp_pkg::CMD_EXEC && !stat.halted) begin
					state_d = simp_pkg::S_DECODE;
				end else begin
					state_d = simp_pkg::S_RESP;
				end
			end
			simp_pkg::S_DECODE: state_d = simp_pkg::S_EXEC;
			simp_pkg::S_EXEC:   state_d = simp_pkg::S_COMMIT;
			simp_pkg::S_COMMIT: begin
				state_d = stat.load_ok ? simp_pkg::S_LOAD : simp_pkg::S_RESP;
			end
			simp_pkg::S_LOAD:   state_d = simp_pkg::S_RESP;
			simp_pkg::S_RESP: begin
				if (!rsp_valid_q || rsp_ready) state_d = simp_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		ctl.mem_op = simp_pkg::MEM_NONE;
		ctl.rf_rd = simp_pkg::RF_RD_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			simp_pkg::S_CLEAR: ctl.mem_op = simp_pkg::MEM_CLEAR;
			simp_pkg::S_IDLE: begin
				req_ready = 1'b1;
				ctl.load_req = req_valid;
			end
			simp_pkg::S_ISSUE: begin
				unique case (stat.cmd)
					simp_pkg::CMD_MEM_WR: ctl.mem_op = simp_pkg::MEM_HOST_WR;
					simp_pkg::CMD_EXEC: begin
						if (!stat.halted) ctl.mem_op = simp_pkg::MEM_FETCH;
					end
					simp_pkg::CMD_MEM_RD: ctl.mem_op = simp_pkg::MEM_HOST_RD;
					simp_pkg::CMD_REG_RD: ctl.rf_rd = simp_pkg::RF_RD_HOST;
				endcase
			end
			simp_pkg::S_DECODE: begin
				ctl.decode = 1'b1;
				ctl.rf_rd = simp_pkg::RF_RD_SRC;
			end
			simp_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				ctl.rf_rd = simp_pkg::RF_RD_DST;
			end
			simp_pkg::S_COMMIT: begin
				ctl.commit = 1'b1;
				if (stat.load_ok) begin
					ctl.mem_op = simp_pkg::MEM_LOAD;
				end else if (stat.store_ok) begin
					ctl.mem_op = simp_pkg::MEM_STORE;
				end
			end
			simp_pkg::S_LOAD: ctl.load_wb = 1'b1;
			simp_pkg::S_RESP: ctl.rsp_load = !rsp_valid_q || rsp_ready;
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rsp_load |-> (!rsp_valid_q || rsp_ready))
		else $error("pending result overwritten");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == simp_pkg::S_CLEAR) |-> !ctl.load_req)
		else $error("item accepted during memory clear");

endmodule

[rtl/simp_dp.sv]
// datapath: main memory, register file, alu, program counter and result register
module simp_dp #(
	parameter int MEM_WORDS = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  simp_pkg::req_t  req,
	input  simp_pkg::ctl_t  ctl,
	output simp_pkg::stat_t stat,
	output simp_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_WORDS);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

	function automatic logic in_mem(input logic [31:0] a);
		return {1'b0, a} < MEM_LIMIT;
	endfunction

	function automatic logic [31:0] opnd(input logic [3:0] idx, input logic [31:0] imm,
			input logic [31:0] rv);
		logic [31:0] v;
		if (idx == simp_pkg::REG_ZERO) begin
			v = '0;
		end else if (idx == simp_pkg::REG_IMM) begin
			v = imm;
		end else begin
			v = rv;
		end
		return v;
	endfunction

	simp_pkg::req_t req_q;
	logic [11:0]    pc_q;
	logic           halt_q;
	logic [AW-1:0]  clr_q;
	logic [7:0]     op_q;
	logic [31:0]    inst_q;
	logic           fetch_ok_q;
	logic [31:0]    mem_rd_q;
	logic [31:0]    rf_a_q, rf_b_q;
	logic [15:0]    rf_vld_q;
	logic [31:0]    res_q;
	logic           take_q;
	logic [AW-1:0]  ls_addr_q;
	logic           ls_ok_q;
	simp_pkg::rsp_t rsp_q;

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rf_mem [16];

	logic [31:0] host32, pc32, inst_w, imm_w, imm_x;
	logic [31:0] a, b, dval, alu, ls_sum;
	logic        take;
	logic [7:0]  op_x;
	logic [3:0]  rd_x;
	logic [11:0] pc1, pc_d;
	logic        halt_d;
	logic [3:0]  ra, rb;
	logic        rf_we;
	logic [3:0]  rf_wa;
	logic [31:0] rf_wd;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0]   mem_wd;
	logic [31:0]   rdata;

	assign host32 = {20'b0, req_q.addr};
	assign pc32   = {20'b0, pc_q};
	assign pc1    = pc_q + 12'd1;
	assign inst_w = fetch_ok_q ? mem_rd_q : '0;
	assign imm_w  = {{20{inst_w[11]}}, inst_w[11:0]};
	assign imm_x  = {{20{inst_q[11]}}, inst_q[11:0]};
	assign op_x   = inst_q[31:24];
	assign rd_x   = inst_q[23:20];
	assign a      = opnd(inst_q[19:16], imm_x, rf_b_q);
	assign b      = opnd(inst_q[15:12], imm_x, rf_a_q);
	assign dval   = opnd(rd_x, imm_x, rf_a_q);
	assign ls_sum = a + b;

	// request register
	always_ff @(posedge clk) begin
		if (ctl.load_req) req_q <= req;
	end

	// executed opcode: zero unless an instruction is decoded for this item
	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			op_q <= '0;
		end else if (ctl.decode) begin
			op_q <= inst_w[31:24];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.decode) inst_q <= inst_w;
	end

	// memory clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.mem_op == simp_pkg::MEM_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// alu and branch compare
	always_comb begin
		unique case (op_x)
			simp_pkg::OP_ADD: alu = a + b;
			simp_pkg::OP_SUB: alu = a - b;
			simp_pkg::OP_AND: alu = a & b;
			simp_pkg::OP_OR:  alu = a | b;
			simp_pkg::OP_XOR: alu = a ^ b;
			simp_pkg::OP_MUL: alu = a * b;
			simp_pkg::OP_SLL: alu = a << b[4:0];
			simp_pkg::OP_SRA: alu = $unsigned($signed(a) >>> b[4:0]);
			simp_pkg::OP_SRL: alu = a >> b[4:0];
			default:          alu = '0;
		endcase
		unique case (op_x)
			simp_pkg::OP_BEQ: take = (a == b);
			simp_pkg::OP_BNE: take = (a != b);
			simp_pkg::OP_BLT: take = ($signed(a) < $signed(b));
			simp_pkg::OP_BGT: take = ($signed(a) > $signed(b));
			simp_pkg::OP_BLE: take = ($signed(a) <= $signed(b));
			simp_pkg::OP_BGE: take = ($signed(a) >= $signed(b));
			default:          take = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			res_q     <= alu;
			take_q    <= take;
			ls_addr_q <= ls_sum[AW-1:0];
			ls_ok_q   <= in_mem(ls_sum);
		end
	end

	// register file write port, pc and halt update
	always_comb begin
		rf_we  = 1'b0;
		rf_wa  = rd_x;
		rf_wd  = res_q;
		pc_d   = pc_q;
		halt_d = halt_q;
		if (ctl.decode) begin
			rf_we = 1'b1;
			rf_wa = simp_pkg::REG_IMM;
			rf_wd = imm_w;
		end else if (ctl.load_wb) begin
			rf_we = (rd_x > simp_pkg::REG_IMM);
			rf_wd = mem_rd_q;
		end else if (ctl.commit) begin
			pc_d = pc1;
			if (op_x <= simp_pkg::OP_SRL) begin
				rf_we = (rd_x > simp_pkg::REG_IMM);
			end else if (op_x == simp_pkg::OP_JAL) begin
				rf_we = 1'b1;
				rf_wa = simp_pkg::REG_LINK;
				rf_wd = {20'b0, pc1};
				pc_d  = dval[11:0];
			end else if (op_x == simp_pkg::OP_HALT) begin
				halt_d = 1'b1;
				pc_d   = pc_q;
			end else if (take_q) begin
				pc_d = dval[11:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halt_q   <= 1'b0;
			rf_vld_q <= '0;
		end else begin
			pc_q   <= pc_d;
			halt_q <= halt_d;
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
	end

	// register file read ports
	always_comb begin
		ra = '0;
		rb = '0;
		unique case (ctl.rf_rd)
			simp_pkg::RF_RD_NONE: ;
			simp_pkg::RF_RD_HOST: ra = req_q.addr[3:0];
			simp_pkg::RF_RD_SRC: begin
				ra = inst_w[15:12];
				rb = inst_w[19:16];
			end
			simp_pkg::RF_RD_DST: ra = inst_q[23:20];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.rf_rd != simp_pkg::RF_RD_NONE) begin
			rf_a_q <= rf_vld_q[ra] ? rf_mem[ra] : '0;
			rf_b_q <= rf_vld_q[rb] ? rf_mem[rb] : '0;
		end
	end

	// main memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = clr_q;
		mem_ra = ls_addr_q;
		mem_wd = '0;
		unique case (ctl.mem_op)
			simp_pkg::MEM_NONE: ;
			simp_pkg::MEM_CLEAR: mem_we = 1'b1;
			simp_pkg::MEM_HOST_WR: begin
				mem_we = in_mem(host32);
				mem_wa = host32[AW-1:0];
				mem_wd = req_q.data;
			end
			simp_pkg::MEM_HOST_RD: begin
				mem_re = 1'b1;
				mem_ra = host32[AW-1:0];
			end
			simp_pkg::MEM_FETCH: begin
				mem_re = 1'b1;
				mem_ra = pc32[AW-1:0];
			end
			simp_pkg::MEM_LOAD: mem_re = 1'b1;
			simp_pkg::MEM_STORE: begin
				mem_we = 1'b1;
				mem_wa = ls_addr_q;
				mem_wd = dval;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_op == simp_pkg::MEM_FETCH) fetch_ok_q <= in_mem(pc32);
	end

	// result register
	always_comb begin
		unique case (req_q.cmd)
			simp_pkg::CMD_MEM_RD: rdata = in_mem(host32) ? mem_rd_q : '0;
			simp_pkg::CMD_REG_RD: begin
				rdata = (req_q.addr[3:0] == simp_pkg::REG_ZERO) ? '0 : rf_a_q;
			end
			default: rdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.rsp_load) begin
			rsp_q.next_pc         <= pc_q;
			rsp_q.halted          <= halt_q;
			rsp_q.read_data       <= rdata;
			rsp_q.executed_opcode <= op_q;
		end
	end

	assign rsp = rsp_q;

	assign stat.cmd      = req_q.cmd;
	assign stat.halted   = halt_q;
	assign stat.clr_last = (clr_q == CLR_LAST);
	assign stat.load_ok  = (op_x == simp_pkg::OP_LW) && ls_ok_q;
	assign stat.store_ok = (op_x == simp_pkg::OP_SW) && ls_ok_q;

	a_r0_never_written: assert property (@(posedge clk) disable iff (!arst_n)
		!rf_vld_q[0])
		else $error("register zero written");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	a_pc_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.commit |=> $stable(pc_q))
		else $error("pc moved outside commit");

	a_halted_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) |-> (ctl.mem_op != simp_pkg::MEM_FETCH))
		else $error("fetch while halted");

endmodule

[tb/sv/tb_simp_risc_instruction_executor.sv]
// self-checking testbench for the simp risc instruction executor: programs, host access, halt
class executor_scoreboard #(int WORDS = 4096);
	logic [31:0]    regs [16];
	logic [31:0]    mem [WORDS];
	logic [11:0]    pc;
	logic           halt;
	simp_pkg::rsp_t pending_rsps [$];
	int             errors;

	function new();
		foreach (regs[i]) regs[i] = '0;
		foreach (mem[i]) mem[i] = '0;
		pc = '0;
		halt = 1'b0;
		errors = 0;
	endfunction

	function void put_reg(logic [3:0] idx, logic [31:0] value);
		if (idx != simp_pkg::REG_ZERO && idx != simp_pkg::REG_IMM)
			regs[idx] = value;
	endfunction

	function logic [7:0] run_instruction();
		logic [31:0] w, a, b, ea;
		logic [7:0]  op;
		logic [3:0]  rd, rs, rt;
		logic [11:0] nxt;
		logic        take;
		w = (int'(pc) < WORDS) ? mem[pc] : '0;
		op = w[31:24];
		rd = w[23:20];
		rs = w[19:16];
		rt = w[15:12];
		regs[simp_pkg::REG_ZERO] = '0;
		regs[simp_pkg::REG_IMM] = {{20{w[11]}}, w[11:0]};
		a = regs[rs];
		b = regs[rt];
		nxt = pc + 12'd1;
		take = 1'b0;
		case (op)
			simp_pkg::OP_ADD: put_reg(rd, a + b);
			simp_pkg::OP_SUB: put_reg(rd, a - b);
			simp_pkg::OP_AND: put_reg(rd, a & b);
			simp_pkg::OP_OR:  put_reg(rd, a | b);
			simp_pkg::OP_XOR: put_reg(rd, a ^ b);
			simp_pkg::OP_MUL: put_reg(rd, a * b);
			simp_pkg::OP_SLL: put_reg(rd, a << b[4:0]);
			simp_pkg::OP_SRA: put_reg(rd, $signed(a) >>> b[4:0]);
			simp_pkg::OP_SRL: put_reg(rd, a >> b[4:0]);
			simp_pkg::OP_BEQ: take = (a == b);
			simp_pkg::OP_BNE: take = (a != b);
			simp_pkg::OP_BLT: take = ($signed(a) < $signed(b));
			simp_pkg::OP_BGT: take = ($signed(a) > $signed(b));
			simp_pkg::OP_BLE: take = ($signed(a) <= $signed(b));
			simp_pkg::OP_BGE: take = ($signed(a) >= $signed(b));
			simp_pkg::OP_JAL: begin
				nxt = regs[rd][11:0];
				regs[simp_pkg::REG_LINK] = {20'd0, 12'(pc + 12'd1)};
			end
			simp_pkg::OP_LW: begin
				ea = a + b;
				if (ea < WORDS)
					put_reg(rd, mem[ea]);
			end
			simp_pkg::OP_SW: begin
				ea = a + b;
				if (ea < WORDS)
					mem[ea] = regs[rd];
			end
			simp_pkg::OP_HALT: begin
				halt = 1'b1;
				nxt = pc;
			end
			default: ;
		endcase
		if (take)
			nxt = regs[rd][11:0];
		regs[simp_pkg::REG_ZERO] = '0;
		pc = nxt;
		return op;
	endfunction

	function void note_item(simp_pkg::req_t item);
		simp_pkg::rsp_t want;
		want = '0;
		case (item.cmd)
			simp_pkg::CMD_MEM_WR: begin
				if (int'(item.addr) < WORDS)
					mem[item.addr] = item.data;
			end
			simp_pkg::CMD_EXEC: begin
				if (!halt)
					want.executed_opcode = run_instruction();
			end
			simp_pkg::CMD_MEM_RD: begin
				if (int'(item.addr) < WORDS)
					want.read_data = mem[item.addr];
			end
			default: begin
				if (item.addr[3:0] != simp_pkg::REG_ZERO)
					want.read_data = regs[item.addr[3:0]];
			end
		endcase
		want.next_pc = pc;
		want.halted = halt;
		pending_rsps.push_back(want);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	task check_result(simp_pkg::rsp_t got);
		simp_pkg::rsp_t want;
		if (pending_rsps.size() == 0) begin
			report("result with none outstanding, next_pc", 32'(got.next_pc), 32'd0);
			return;
		end
		want = pending_rsps.pop_front();
		if (got.next_pc !== want.next_pc)
			report("next_pc", 32'(got.next_pc), 32'(want.next_pc));
		if (got.halted !== want.halted)
			report("halted", 32'(got.halted), 32'(want.halted));
		if (got.read_data !== want.read_data)
			report("read_data", got.read_data, want.read_data);
		if (got.executed_opcode !== want.executed_opcode)
			report("executed_opcode", 32'(got.executed_opcode), 32'(want.executed_opcode));
	endtask
endclass

module tb_simp_risc_instruction_executor;
	localparam int MEM_WORDS   = 4096;
	localparam int IDLE_PCT    = 34;
	localparam int STALL_LIMIT = 20000;
	localparam int ITEM_COUNT  = 1950;

	logic clk, arst_n;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	simp_pkg::req_t req;
	simp_pkg::rsp_t rsp;

	executor_scoreboard #(MEM_WORDS) sb;
	int   items_sent;
	int   quiet_cycles = 0;
	logic calm;

	simp_risc_instruction_executor #(.MEM_WORDS(MEM_WORDS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic simp_pkg::req_t make_req(simp_pkg::cmd_t cmd, logic [11:0] addr,
			logic [31:0] data);
		simp_pkg::req_t item;
		item.cmd = cmd;
		item.addr = addr;
		item.data = data;
		return item;
	endfunction

	function automatic logic [31:0] encode(logic [7:0] op, logic [3:0] rd, logic [3:0] rs,
			logic [3:0] rt, logic [11:0] imm);
		return {op, rd, rs, rt, imm};
	endfunction

	function automatic logic [31:0] random_instr();
		logic [7:0] op;
		logic [3:0] rs, rt;
		if ($urandom_range(99) < 88) begin
			op = 8'($urandom_range(17));
		end else begin
			op = 8'($urandom_range(255, 18));
			if (op == simp_pkg::OP_HALT)
				op = simp_pkg::OP_HALT + 8'd1;
		end
		rs = 4'($urandom);
		rt = 4'($urandom);
		// immediate-only addresses, in range when not negative, for about half of the loads and stores
		if ((op == simp_pkg::OP_LW || op == simp_pkg::OP_SW) && $urandom_range(1) == 1) begin
			rs = simp_pkg::REG_IMM;
			rt = simp_pkg::REG_ZERO;
		end
		return encode(op, 4'($urandom), rs, rt, 12'($urandom));
	endfunction

	task automatic send_item(simp_pkg::req_t item);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		sb.note_item(item);
		items_sent++;
		calm = (items_sent >= 800 && items_sent < 1100);
	endtask

	task automatic write_word(logic [11:0] addr, logic [31:0] data);
		send_item(make_req(simp_pkg::CMD_MEM_WR, addr, data));
	endtask

	task automatic read_mem(logic [11:0] addr);
		send_item(make_req(simp_pkg::CMD_MEM_RD, addr, $urandom));
	endtask

	task automatic read_reg(logic [3:0] idx);
		send_item(make_req(simp_pkg::CMD_REG_RD, {8'($urandom), idx}, $urandom));
	endtask

	task automatic execute();
		send_item(make_req(simp_pkg::CMD_EXEC, 12'($urandom), $urandom));
	endtask

	// halt is kept for the end of the run, so it is patched out of the way here
	task automatic step_safely();
		if (sb.mem[sb.pc][31:24] == simp_pkg::OP_HALT)
			write_word(sb.pc, random_instr());
		execute();
	endtask

	task automatic run_program();
		logic [11:0] base;
		int          n, runs;
		base = sb.pc;
		n = $urandom_range(8, 1);
		for (int i = 0; i < n; i++)
			write_word(base + 12'(i), random_instr());
		runs = ($urandom_range(99) < 12) ? $urandom_range(n + 4) : n;
		for (int i = 0; i < runs; i++) begin
			if ($urandom_range(9) == 0)
				read_reg(4'($urandom));
			step_safely();
		end
	endtask

	initial begin
		simp_pkg::req_t item;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		read_mem(12'hFFF);
		read_reg(simp_pkg::REG_LINK);
		write_word(12'hFFF, 32'hFFFF_FFFF);
		read_mem(12'hFFF);
		write_word(12'h000, encode(simp_pkg::OP_ADD, 4'd2, simp_pkg::REG_IMM,
			simp_pkg::REG_ZERO, 12'h7FF));
		write_word(12'h001, encode(simp_pkg::OP_ADD, 4'd3, simp_pkg::REG_IMM,
			simp_pkg::REG_ZERO, 12'h800));
		write_word(12'h002, encode(simp_pkg::OP_MUL, 4'd4, 4'd3, 4'd3, 12'h000));
		write_word(12'h003, encode(simp_pkg::OP_SRA, 4'd5, 4'd3, simp_pkg::REG_IMM, 12'h01F));
		write_word(12'h004, encode(simp_pkg::OP_SRL, 4'd6, 4'd3, simp_pkg::REG_IMM, 12'hFFF));
		write_word(12'h005, encode(simp_pkg::OP_SW, 4'd3, simp_pkg::REG_IMM,
			simp_pkg::REG_ZERO, 12'h7FF));
		write_word(12'h006, encode(simp_pkg::OP_LW, 4'd7, simp_pkg::REG_IMM,
			simp_pkg::REG_ZERO, 12'h7FF));
		// negative address, load is dropped
		write_word(12'h007, encode(simp_pkg::OP_LW, 4'd8, 4'd3, simp_pkg::REG_ZERO, 12'h000));
		write_word(12'h008, encode(simp_pkg::OP_JAL, 4'd2, simp_pkg::REG_ZERO,
			simp_pkg::REG_ZERO, 12'h000));
		repeat (9) execute();
		read_reg(4'd4);
		read_reg(simp_pkg::REG_LINK);

		while (items_sent < ITEM_COUNT) begin
			if ($urandom_range(5) == 0) begin
				repeat ($urandom_range(4, 1)) begin
					item = make_req(simp_pkg::cmd_t'($urandom_range(3)), 12'($urandom),
						$urandom);
					if (item.cmd == simp_pkg::CMD_EXEC)
						step_safely();
					else
						send_item(item);
				end
			end else begin
				run_program();
			end
		end

		write_word(sb.pc, encode(simp_pkg::OP_HALT, 4'($urandom), 4'($urandom), 4'($urandom),
			12'($urandom)));
		execute();
		execute();
		write_word(12'($urandom), $urandom);
		read_mem(sb.pc);
		read_reg(simp_pkg::REG_LINK);
		execute();
		req_valid <= 1'b0;

		while (sb.pending_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
